// ===== design/motion_event_gate_unit_defines.svh =====
// Assertion helpers used by meg_back.
`ifndef MOTION_EVENT_GATE_UNIT_DEFINES_SVH
`define MOTION_EVENT_GATE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MEG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MEG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/meg_pkg.sv =====
package meg_pkg;

  localparam int unsigned CLASS_W = 3;

  localparam logic [CLASS_W-1:0] CLS_IDLE  = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_ACCEL = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_BRAKE = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_LEFT  = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_RIGHT = 3'd4;

  localparam logic [2:0] REG_SPEEDUP = 3'd0;
  localparam logic [2:0] REG_BRAKE   = 3'd1;
  localparam logic [2:0] REG_TURN    = 3'd2;
  localparam logic [2:0] REG_INVERT  = 3'd3;
  localparam logic [2:0] REG_COOL    = 3'd4;
  localparam logic [2:0] REG_DWELL   = 3'd5;

  typedef struct packed {
    logic signed [15:0] speedup_threshold;
    logic signed [15:0] brake_threshold;
    logic [14:0]        turn_threshold;
    logic               yaw_flip;
    logic [31:0]        refire_gap;
    logic [31:0]        rearm_dwell;
  } cfg_regs_t;

  // One classified sample waiting for the gate.
  typedef struct packed {
    logic [CLASS_W-1:0] motion_class;
    logic [31:0]        now_ms;
  } queue_entry_t;

endpackage

// ===== design/meg_front.sv =====
module meg_front (
  input  meg_pkg::cfg_regs_t    cfg,
  input  logic                  s_axis_tvalid,
  input  logic [63:0]           s_axis_tdata,
  input  logic                  q_full,
  output logic                  s_axis_tready,
  output logic                  q_push,
  output meg_pkg::queue_entry_t q_entry
);
  import meg_pkg::*;

  logic signed [15:0] fwd;
  logic signed [15:0] yaw_raw;
  logic signed [15:0] yaw;
  logic signed [16:0] neg_turn;
  logic signed [16:0] pos_turn;
  logic signed [16:0] yaw_ext;
  logic [CLASS_W-1:0] cls;

  assign fwd     = s_axis_tdata[15:0];
  assign yaw_raw = s_axis_tdata[31:16];

  // negating the most negative count saturates
  always_comb begin
    if (!cfg.yaw_flip) begin
      yaw = yaw_raw;
    end else if (yaw_raw == 16'sh8000) begin
      yaw = 16'sh7fff;
    end else begin
      yaw = -yaw_raw;
    end
  end

  assign pos_turn = signed'({2'b00, cfg.turn_threshold});
  assign neg_turn = -pos_turn;
  assign yaw_ext  = 17'(yaw);

  always_comb begin
    priority if (yaw_ext < neg_turn) begin
      cls = CLS_LEFT;
    end else if (yaw_ext > pos_turn) begin
      cls = CLS_RIGHT;
    end else if (fwd > cfg.speedup_threshold) begin
      cls = CLS_ACCEL;
    end else if (fwd < cfg.brake_threshold) begin
      cls = CLS_BRAKE;
    end else begin
      cls = CLS_IDLE;
    end
  end

  assign s_axis_tready        = !q_full;
  assign q_push               = s_axis_tvalid && !q_full;
  assign q_entry.motion_class = cls;
  assign q_entry.now_ms       = s_axis_tdata[63:32];

endmodule

// ===== design/meg_queue.sv =====
module meg_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  meg_pkg::queue_entry_t push_entry,
  input  logic                  pop,
  output logic                  full,
  output logic                  not_empty,
  output meg_pkg::queue_entry_t head
);
  import meg_pkg::*;

  queue_entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

endmodule

// ===== design/meg_back.sv =====
`include "motion_event_gate_unit_defines.svh"

module meg_back (
  input  logic                  clk,
  input  logic                  rst,
  input  meg_pkg::cfg_regs_t    cfg,
  input  logic                  q_not_empty,
  input  meg_pkg::queue_entry_t q_head,
  output logic                  q_pop,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata
);
  import meg_pkg::*;

  logic               armed_flag;
  logic               armed_flag_next;
  logic [31:0]        last_trigger_time;
  logic [31:0]        idle_start_time;
  logic               idle_valid;
  logic               is_idle;
  logic               cool_ok;
  logic               dwell_ok;
  logic               fire;
  logic [31:0]        idle_base;
  logic [CLASS_W-1:0] out_class;
  logic               out_trig;
  logic               out_armed;

  assign q_pop = q_not_empty && (!m_axis_tvalid || m_axis_tready);

  assign is_idle   = (q_head.motion_class == CLS_IDLE);
  assign cool_ok   = (q_head.now_ms - last_trigger_time) >= cfg.refire_gap;
  // a fresh idle run starts at this very sample
  assign idle_base = idle_valid ? idle_start_time : q_head.now_ms;
  assign dwell_ok  = (q_head.now_ms - idle_base) >= cfg.rearm_dwell;
  assign fire      = armed_flag && cool_ok && !is_idle;

  always_comb begin
    armed_flag_next = armed_flag;
    if (fire) begin
      armed_flag_next = 1'b0;
    end else if (is_idle && !armed_flag && dwell_ok) begin
      armed_flag_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_flag        <= 1'b1;
      last_trigger_time <= 32'd0;
      idle_start_time   <= 32'd0;
      idle_valid        <= 1'b0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      if (q_pop) begin
        armed_flag <= armed_flag_next;
        if (fire) begin
          last_trigger_time <= q_head.now_ms;
          idle_valid        <= 1'b0;
        end else if (is_idle) begin
          idle_start_time <= idle_base;
          idle_valid      <= 1'b1;
        end else begin
          idle_valid <= 1'b0;
        end
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_class <= q_head.motion_class;
      out_trig  <= fire;
      out_armed <= armed_flag_next;
    end
  end

  assign m_axis_tdata = {3'b000, out_armed, out_trig, out_class};

  `MEG_ASSERT_NOW(a_trig_disarms, m_axis_tvalid && out_trig, !out_armed, "trigger left gate armed")
  `MEG_ASSERT_NOW(a_trig_not_idle, m_axis_tvalid && out_trig, out_class != CLS_IDLE, "idle fired")
  `MEG_ASSERT_NEXT(a_fire_clears, q_pop && fire, !armed_flag && !idle_valid, "fire kept state")
  `MEG_ASSERT_NEXT(a_pop_shows, q_pop, m_axis_tvalid, "popped sample not presented")

endmodule

// ===== design/motion_event_gate_unit.sv =====
// Motion event gate. Each input word is one IMU sample (forward accel, yaw rate,
// ms timestamp); each output word is its class, trigger flag and armed state.
// Exactly one output word per input word, in order. Throughput is one word per
// clock while the master side accepts; a word that is taken passes through the
// two-entry queue between the classifier and the gate logic and then the output
// register before it appears on the master side. Configuration writes are always
// accepted and should be made only while no word is in flight.
module motion_event_gate_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // fwd_accel[15:0], yaw_rate[31:16], now_ms[63:32]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // motion_class[2:0], triggered[3], armed[4], zero[7:5]
  output logic [7:0]  m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import meg_pkg::*;

  cfg_regs_t    cfg;
  queue_entry_t push_entry;
  queue_entry_t head;
  logic         push;
  logic         pop;
  logic         full;
  logic         not_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speedup_threshold <= 16'sd1671;
      cfg.brake_threshold   <= -16'sd1671;
      cfg.turn_threshold    <= 15'd655;
      cfg.yaw_flip          <= 1'b0;
      cfg.refire_gap        <= 32'd3000;
      cfg.rearm_dwell       <= 32'd500;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SPEEDUP: cfg.speedup_threshold <= cfg_data[15:0];
        REG_BRAKE:   cfg.brake_threshold   <= cfg_data[15:0];
        REG_TURN:    cfg.turn_threshold    <= cfg_data[14:0];
        REG_INVERT:  cfg.yaw_flip          <= cfg_data[0];
        REG_COOL:    cfg.refire_gap        <= cfg_data;
        REG_DWELL:   cfg.rearm_dwell       <= cfg_data;
        default:     cfg                   <= cfg;
      endcase
    end
  end

  meg_front u_front (
    .cfg           (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .q_full        (full),
    .s_axis_tready (s_axis_tready),
    .q_push        (push),
    .q_entry       (push_entry)
  );

  meg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .not_empty  (not_empty),
    .head       (head)
  );

  meg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_not_empty   (not_empty),
    .q_head        (head),
    .q_pop         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
